FILE: src/vad_hangover_relabel_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hangover relabel block
// Expect signals named clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef VAD_HANGOVER_RELABEL_ASSERT_SVH
`define VAD_HANGOVER_RELABEL_ASSERT_SVH

// same-cycle implication
`define VHR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vhr: assertion failed");

// next-cycle implication
`define VHR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vhr: assertion failed");

`endif

FILE: src/vhr_pkg.sv
// ----------------------------------------------------------------------------
// vhr_pkg
// Shared constants, command type and trap helper for the hangover relabel
// block.
// ----------------------------------------------------------------------------
package vhr_pkg;

  // sizes
  localparam int HOLD_DEPTH  = 32;
  localparam int TAG_WIDTH   = 16;
  localparam int TRAP_W      = 6;
  localparam int PTR_W       = $clog2(HOLD_DEPTH);
  localparam int CNT_W       = $clog2(HOLD_DEPTH + 1);
  localparam int WIDE_W      = TRAP_W + CNT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // register reset value
  localparam logic [TRAP_W-1:0] TRAP_RESET = TRAP_W'(8);

  // input opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // command kinds between front and back
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // register index (paddr bit above the word offset)
  localparam logic REG_SIL_TRAP    = 1'b0;
  localparam logic REG_SPEECH_TRAP = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [TAG_WIDTH-1:0] tag;
    logic                 speech;
  } cmd_t;

  typedef struct packed {
    logic [TRAP_W-1:0] sil_trap;
    logic [TRAP_W-1:0] speech_trap;
  } trap_cfg_t;

  // zero acts as one, anything beyond the store saturates to its depth
  function automatic logic [CNT_W-1:0] eff_trap(input logic [TRAP_W-1:0] t);
    logic [WIDE_W-1:0] wide;
    wide = {{CNT_W{1'b0}}, t};
    if (t == '0) begin
      eff_trap = CNT_W'(1);
    end else if (wide > WIDE_W'(HOLD_DEPTH)) begin
      eff_trap = CNT_W'(HOLD_DEPTH);
    end else begin
      eff_trap = wide[CNT_W-1:0];
    end
  endfunction

endpackage

FILE: src/vhr_chan_if.sv
// ----------------------------------------------------------------------------
// vhr channel interfaces
// Valid/ready channels for frame requests and relabelled results.
// ----------------------------------------------------------------------------
interface vhr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [vhr_pkg::TAG_WIDTH-1:0] frame_tag;
  logic                          frame_is_speech;

  modport source (output valid, opcode, frame_tag, frame_is_speech, input ready);
  modport sink   (input valid, opcode, frame_tag, frame_is_speech, output ready);
endinterface

interface vhr_out_if;
  logic                          valid;
  logic                          ready;
  logic [vhr_pkg::TAG_WIDTH-1:0] out_tag;
  logic                          out_is_speech;
  logic                          last;

  modport source (output valid, out_tag, out_is_speech, last, input ready);
  modport sink   (input valid, out_tag, out_is_speech, last, output ready);
endinterface

FILE: src/vhr_front.sv
// ----------------------------------------------------------------------------
// vhr_front
// Accepts frame requests and decodes them into commands for the back end.
// ----------------------------------------------------------------------------
module vhr_front (
  input  logic           clk,
  input  logic           rst,
  vhr_in_if.sink         frames,
  output logic           cmd_valid,
  output vhr_pkg::cmd_t  cmd,
  input  logic           cmd_ready
);
  import vhr_pkg::*;

  logic hold_valid;
  cmd_t hold_cmd;
  cmd_t dec_cmd;

  // take a new request whenever the stage is empty or draining
  assign frames.ready = !hold_valid || cmd_ready;

  // classify: flushes carry no frame, frames keep tag and raw decision
  always_comb begin
    dec_cmd.kind   = (frames.opcode == OP_FLUSH) ? CMD_FLUSH : CMD_FRAME;
    dec_cmd.tag    = frames.frame_tag;
    dec_cmd.speech = frames.frame_is_speech;
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (frames.valid && frames.ready) begin
      hold_valid <= 1'b1;
      hold_cmd   <= dec_cmd;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  assign cmd_valid = hold_valid;
  assign cmd       = hold_cmd;

endmodule

FILE: src/vhr_queue.sv
// ----------------------------------------------------------------------------
// vhr_queue
// Short command queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module vhr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  vhr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output vhr_pkg::cmd_t pop_cmd
);
  import vhr_pkg::*;

  localparam int Q_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t               entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != Q_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: src/vhr_back.sv
// ----------------------------------------------------------------------------
// vhr_back
// Hysteresis state, hold store and release sequencer; drives the result
// register.
// ----------------------------------------------------------------------------
module vhr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  vhr_pkg::cmd_t      cmd,
  input  vhr_pkg::trap_cfg_t traps,
  vhr_out_if.source          results
);
  import vhr_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [TAG_WIDTH-1:0] mem [HOLD_DEPTH];

  logic [1:0]           state;
  logic                 in_speech;
  logic [CNT_W-1:0]     held_count;
  logic [PTR_W-1:0]     read_pointer;
  logic                 rel_label;
  logic                 tail_pending;
  logic [TAG_WIDTH-1:0] tail_tag;
  logic [TAG_WIDTH-1:0] rd_data;
  logic                 out_valid;
  logic [TAG_WIDTH-1:0] out_tag;
  logic                 out_is_speech;
  logic                 out_last;

  logic [SUM_W-1:0]     wr_sum;
  logic [PTR_W-1:0]     wr_addr;
  logic [PTR_W-1:0]     rp_next;
  logic [CNT_W-1:0]     count_inc;
  logic [CNT_W-1:0]     trap_eff;
  logic                 take;
  logic                 hold_frame;
  logic                 out_free;

  assign cmd_ready = (state == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign out_free  = !out_valid || results.ready;

  // tail of the ring, with wrap
  always_comb begin
    wr_sum  = SUM_W'(read_pointer) + SUM_W'(held_count);
    wr_addr = (wr_sum >= SUM_W'(HOLD_DEPTH)) ? PTR_W'(wr_sum - SUM_W'(HOLD_DEPTH))
                                             : PTR_W'(wr_sum);
    rp_next = (read_pointer == PTR_W'(HOLD_DEPTH - 1)) ? '0 : read_pointer + 1'b1;
  end

  // frame disagreeing with the current state gets held
  assign hold_frame = take && (cmd.kind == CMD_FRAME) && (cmd.speech != in_speech);
  assign count_inc  = held_count + 1'b1;
  assign trap_eff   = eff_trap(in_speech ? traps.speech_trap : traps.sil_trap);

  // hold store: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (hold_frame) begin
      mem[wr_addr] <= cmd.tag;
    end
    rd_data <= mem[read_pointer];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_speech    <= 1'b0;
      held_count   <= '0;
      read_pointer <= '0;
      tail_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            if (cmd.kind == CMD_FLUSH) begin
              rel_label    <= in_speech;
              tail_pending <= 1'b0;
              if (held_count != '0) begin
                state <= S_READ;
              end
            end else if (cmd.speech == in_speech) begin
              // agreeing frame: held frames revert, then the frame itself
              rel_label    <= in_speech;
              tail_pending <= 1'b1;
              tail_tag     <= cmd.tag;
              state        <= (held_count != '0) ? S_READ : S_TAIL;
            end else begin
              held_count <= count_inc;
              if (count_inc >= trap_eff) begin
                rel_label    <= cmd.speech;
                in_speech    <= cmd.speech;
                tail_pending <= 1'b0;
                state        <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_tag       <= rd_data;
            out_is_speech <= rel_label;
            out_last      <= (held_count == CNT_W'(1)) && !tail_pending;
            read_pointer  <= rp_next;
            held_count    <= held_count - 1'b1;
            if (held_count == CNT_W'(1)) begin
              state <= tail_pending ? S_TAIL : S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_TAIL: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_tag       <= tail_tag;
            out_is_speech <= in_speech;
            out_last      <= 1'b1;
            tail_pending  <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid         = out_valid;
  assign results.out_tag       = out_tag;
  assign results.out_is_speech = out_is_speech;
  assign results.last          = out_last;

endmodule

FILE: src/vad_hangover_relabel.sv
// An accepted request passes the front command register and the queue before
// the back end takes it. Each released frame goes through a registered read
// of the hold store, then the result register; a request that releases
// nothing stays in idle; an agreeing frame with nothing held skips the read.
// Reset clears state to silence, empties the hold store and sets both traps
// to 8; the stored tags themselves are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// vad_hangover_relabel
// Two-sided hangover smoothing of per-frame speech decisions, with an APB
// register port for the trap counts.
// ----------------------------------------------------------------------------
module vad_hangover_relabel (
  input  logic                          clk,
  input  logic                          rst,
  vhr_in_if.sink                        frames,
  vhr_out_if.source                     results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vhr_pkg::ADDR_W-1:0]    paddr,
  input  logic [vhr_pkg::DATA_W-1:0]    pwdata,
  output logic [vhr_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import vhr_pkg::*;

  logic      f_valid;
  cmd_t      f_cmd;
  logic      f_ready;
  logic      q_valid;
  cmd_t      q_cmd;
  logic      q_ready;
  trap_cfg_t traps;
  logic      reg_sel;
  logic      cfg_write;

  // register file
  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      traps.sil_trap    <= TRAP_RESET;
      traps.speech_trap <= TRAP_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_SPEECH_TRAP) begin
        traps.speech_trap <= pwdata[TRAP_W-1:0];
      end else begin
        traps.sil_trap <= pwdata[TRAP_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_SPEECH_TRAP) ? DATA_W'(traps.speech_trap)
                                               : DATA_W'(traps.sil_trap);

  vhr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .frames    (frames),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  vhr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  vhr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .traps     (traps),
    .results   (results)
  );

endmodule

FILE: src/vhr_checker.sv
// ----------------------------------------------------------------------------
// vhr_checker
// Port-level checks on the hangover relabel block, bound to the top level.
// ----------------------------------------------------------------------------
`include "vad_hangover_relabel_assert.svh"

module vhr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [vhr_pkg::TAG_WIDTH-1:0] out_tag,
  input logic                          out_is_speech,
  input logic                          out_last,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [vhr_pkg::ADDR_W-1:0]    paddr,
  input logic [vhr_pkg::DATA_W-1:0]    pwdata,
  input logic [vhr_pkg::DATA_W-1:0]    prdata
);
  import vhr_pkg::*;

  // a stalled result holds still
  `VHR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tag) && $stable(out_is_speech) && $stable(out_last))

  // no result left over straight after reset
  `VHR_ASSERT_IMP(a_out_clear, $past(rst), !out_valid)

  // trap registers read back with no stray high bits
  `VHR_ASSERT_IMP(a_rd_upper, 1'b1, prdata[DATA_W-1:TRAP_W] == '0)

  // a write to the silence trap is seen by a read the next cycle
  `VHR_ASSERT_NXT(a_rd_back, psel && penable && pwrite && paddr[ADDR_W-1] == REG_SIL_TRAP, !(psel && !pwrite && paddr[ADDR_W-1] == REG_SIL_TRAP) || prdata[TRAP_W-1:0] == $past(pwdata[TRAP_W-1:0]))

endmodule

bind vad_hangover_relabel vhr_checker u_vhr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_tag       (results.out_tag),
  .out_is_speech (results.out_is_speech),
  .out_last      (results.last),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
